### sv/djd_pkg.sv
// ----------------------------------------------------------------------------
// djd_pkg
// Types, constants and sizes shared by the drum jam detect controller.
// ----------------------------------------------------------------------------
package djd_pkg;

	localparam int CMD_W    = 16;
	localparam int CUR_W    = 12;
	localparam int POS_W    = 32;
	localparam int TRIG_W   = 16;
	localparam int PWR_W    = 2;
	localparam int MODE_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int WINDOW_DEPTH     = 8;
	localparam int UNJAM_DISTANCE   = 512;
	localparam int TRIGGER_DEADBAND = 3277;

	localparam int CUR_MAX = (1 << CUR_W) - 1;
	localparam int SUM_W   = $clog2(WINDOW_DEPTH * CUR_MAX + 1);

	localparam logic [TRIG_W-1:0]     DEADBAND     = TRIG_W'(TRIGGER_DEADBAND);
	localparam logic signed [POS_W:0] UNJAM_DIST_X = (POS_W + 1)'(UNJAM_DISTANCE);

	// -0.25 in Q1.15
	localparam logic signed [CMD_W-1:0] REVERSE_THROAT = -16'sd8192;
	localparam logic signed [CMD_W-1:0] CMD_MIN        = -16'sd32768;
	localparam logic signed [CMD_W-1:0] CMD_MAX        = 16'sd32767;

	typedef enum logic [MODE_W-1:0] {
		MODE_STOPPED = 3'd0,
		MODE_LOW     = 3'd1,
		MODE_HIGH    = 3'd2,
		MODE_UNJAM   = 3'd3,
		MODE_REVERSE = 3'd4
	} mode_t;

	typedef enum logic [PWR_W-1:0] {
		PWR_FENDER     = 2'd0,
		PWR_INITIATION = 2'd1,
		PWR_TRENCH     = 2'd2,
		PWR_OTHER      = 2'd3
	} power_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DRUM_LOW        = 3'd0,
		REG_DRUM_FENDER     = 3'd1,
		REG_DRUM_INITIATION = 3'd2,
		REG_DRUM_TRENCH     = 3'd3,
		REG_DRUM_OTHER      = 3'd4,
		REG_THROAT_LEAD     = 3'd5,
		REG_THROAT_FOLLOW   = 3'd6,
		REG_JAM_THRESHOLD   = 3'd7
	} reg_idx_t;

	localparam logic signed [CMD_W-1:0] RST_DRUM_LOW  = 16'sd8192;
	localparam logic signed [CMD_W-1:0] RST_SPEED     = 16'sd16384;
	localparam logic [CUR_W-1:0]        RST_THRESHOLD = 12'd480;

	typedef struct packed {
		logic signed [CMD_W-1:0] drum_low_speed;
		logic signed [CMD_W-1:0] drum_speed_fender;
		logic signed [CMD_W-1:0] drum_speed_initiation;
		logic signed [CMD_W-1:0] drum_speed_trench;
		logic signed [CMD_W-1:0] drum_speed_other;
		logic signed [CMD_W-1:0] throat_lead_speed;
		logic signed [CMD_W-1:0] throat_follow_speed;
		logic [CUR_W-1:0]        jam_threshold;
	} cfg_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} win_ctl_t;

endpackage

### sv/djd_in_if.sv
// ----------------------------------------------------------------------------
// djd_in_if
// Per-tick input channel: joystick, sensor and encoder readings.
// ----------------------------------------------------------------------------
interface djd_in_if;
	logic                              valid;
	logic                              ready;
	logic [djd_pkg::TRIG_W-1:0]        trigger_level;
	logic                              reverse_request;
	logic                              intake_deployed;
	logic                              flywheel_ready;
	logic [djd_pkg::PWR_W-1:0]         power_mode;
	logic [djd_pkg::CUR_W-1:0]         drum_current;
	logic signed [djd_pkg::POS_W-1:0]  encoder_position;

	modport source (
		output valid, trigger_level, reverse_request, intake_deployed,
		       flywheel_ready, power_mode, drum_current, encoder_position,
		input  ready
	);
	modport sink (
		input  valid, trigger_level, reverse_request, intake_deployed,
		       flywheel_ready, power_mode, drum_current, encoder_position,
		output ready
	);
endinterface

### sv/djd_out_if.sv
// ----------------------------------------------------------------------------
// djd_out_if
// Per-tick result channel: motor commands, drum mode and average current.
// ----------------------------------------------------------------------------
interface djd_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [djd_pkg::CMD_W-1:0]  drum_command;
	logic signed [djd_pkg::CMD_W-1:0]  throat_lead_command;
	logic signed [djd_pkg::CMD_W-1:0]  throat_follow_command;
	logic [djd_pkg::MODE_W-1:0]        drum_mode;
	logic [djd_pkg::CUR_W-1:0]         average_current;

	modport source (
		output valid, drum_command, throat_lead_command, throat_follow_command,
		       drum_mode, average_current,
		input  ready
	);
	modport sink (
		input  valid, drum_command, throat_lead_command, throat_follow_command,
		       drum_mode, average_current,
		output ready
	);
endinterface

### sv/djd_cfg_regs.sv
// ----------------------------------------------------------------------------
// djd_cfg_regs
// Speed and jam threshold register file behind the plain write port.
// ----------------------------------------------------------------------------
module djd_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [djd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [djd_pkg::CFG_DATA_W-1:0]     cfg_data,
	output djd_pkg::cfg_t                      cfg
);

	djd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drum_low_speed        <= djd_pkg::RST_DRUM_LOW;
			cfg_q.drum_speed_fender     <= djd_pkg::RST_SPEED;
			cfg_q.drum_speed_initiation <= djd_pkg::RST_SPEED;
			cfg_q.drum_speed_trench     <= djd_pkg::RST_SPEED;
			cfg_q.drum_speed_other      <= djd_pkg::RST_SPEED;
			cfg_q.throat_lead_speed     <= djd_pkg::RST_SPEED;
			cfg_q.throat_follow_speed   <= djd_pkg::RST_SPEED;
			cfg_q.jam_threshold         <= djd_pkg::RST_THRESHOLD;
		end else if (cfg_we) begin
			case (djd_pkg::reg_idx_t'(cfg_index))
				djd_pkg::REG_DRUM_LOW:        cfg_q.drum_low_speed        <= cfg_data;
				djd_pkg::REG_DRUM_FENDER:     cfg_q.drum_speed_fender     <= cfg_data;
				djd_pkg::REG_DRUM_INITIATION: cfg_q.drum_speed_initiation <= cfg_data;
				djd_pkg::REG_DRUM_TRENCH:     cfg_q.drum_speed_trench     <= cfg_data;
				djd_pkg::REG_DRUM_OTHER:      cfg_q.drum_speed_other      <= cfg_data;
				djd_pkg::REG_THROAT_LEAD:     cfg_q.throat_lead_speed     <= cfg_data;
				djd_pkg::REG_THROAT_FOLLOW:   cfg_q.throat_follow_speed   <= cfg_data;
				djd_pkg::REG_JAM_THRESHOLD: begin
					cfg_q.jam_threshold <= cfg_data[djd_pkg::CUR_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/djd_win_cell.sv
// ----------------------------------------------------------------------------
// djd_win_cell
// One slot of the current window: holds a sample and passes it down the row.
// ----------------------------------------------------------------------------
module djd_win_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  djd_pkg::win_ctl_t             ctl,
	input  logic [djd_pkg::CUR_W-1:0]     d,
	output logic [djd_pkg::CUR_W-1:0]     q
);

	logic [djd_pkg::CUR_W-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (ctl.clear) begin
			sample_q <= '0;
		end else if (ctl.shift) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

### sv/djd_window.sv
// ----------------------------------------------------------------------------
// djd_window
// Row of window cells with a running sum; gives the floor average that
// includes the incoming sample.
// ----------------------------------------------------------------------------
module djd_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  djd_pkg::win_ctl_t             ctl,
	input  logic [djd_pkg::CUR_W-1:0]     sample,
	output logic [djd_pkg::CUR_W-1:0]     avg
);

	logic [djd_pkg::CUR_W-1:0] tap [djd_pkg::WINDOW_DEPTH];
	logic [djd_pkg::SUM_W-1:0] sum_q;
	logic [djd_pkg::SUM_W-1:0] sum_next;
	logic [djd_pkg::SUM_W-1:0] quot;

	for (genvar i = 0; i < djd_pkg::WINDOW_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			djd_win_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.d      (sample),
				.q      (tap[i])
			);
		end else begin : g_body
			djd_win_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.d      (tap[i-1]),
				.q      (tap[i])
			);
		end
	end

	// oldest sample leaves from the tail as the new one enters the head
	assign sum_next = sum_q - djd_pkg::SUM_W'(tap[djd_pkg::WINDOW_DEPTH-1])
	                + djd_pkg::SUM_W'(sample);
	assign quot = djd_pkg::SUM_W'(sum_next / djd_pkg::WINDOW_DEPTH);
	assign avg  = quot[djd_pkg::CUR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.clear) begin
			sum_q <= '0;
		end else if (ctl.shift) begin
			sum_q <= sum_next;
		end
	end

endmodule

### sv/drum_jam_detect_controller.sv
// ----------------------------------------------------------------------------
// drum_jam_detect_controller
// Picks the drum mode each tick, watches the average drum current for jams,
// runs the unjam move by encoder distance and holds the motor commands.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  item     | in        | trigger, buttons, flywheel, power mode, current, position
//  result   | out       | drum and throat commands, drum mode, average current
//  cfg_*    | in        | write-only speed and jam threshold registers
//
// a new item is taken every cycle the result register is empty or being drained.
// the result appears in the cycle after its item is taken, from the result
// register after the window row and the mode logic.
// reset clears mode, window, jam position and held commands at once.
// a stalled result holds its register and blocks only further items.
// ----------------------------------------------------------------------------
module drum_jam_detect_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	djd_in_if.sink                            item,
	djd_out_if.source                         result,
	input  logic                              cfg_we,
	input  logic [djd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [djd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	djd_pkg::cfg_t      cfg;
	djd_pkg::win_ctl_t  win_ctl;
	djd_pkg::mode_t     mode_q;
	djd_pkg::mode_t     mode_sel;
	djd_pkg::mode_t     mode_jam;
	djd_pkg::mode_t     mode_next;

	logic [djd_pkg::CUR_W-1:0]        avg;
	logic                             accept;
	logic                             jam;
	logic                             unjam_done;
	logic signed [djd_pkg::POS_W-1:0] start_q;
	logic signed [djd_pkg::POS_W-1:0] start_next;
	logic signed [djd_pkg::POS_W:0]   pos_x;
	logic signed [djd_pkg::POS_W:0]   limit_x;
	logic signed [djd_pkg::CMD_W-1:0] low_neg;
	logic signed [djd_pkg::CMD_W-1:0] high_drum;
	logic signed [djd_pkg::CMD_W-1:0] drum_q;
	logic signed [djd_pkg::CMD_W-1:0] lead_q;
	logic signed [djd_pkg::CMD_W-1:0] follow_q;
	logic signed [djd_pkg::CMD_W-1:0] drum_next;
	logic signed [djd_pkg::CMD_W-1:0] lead_next;
	logic signed [djd_pkg::CMD_W-1:0] follow_next;

	logic                             out_valid_q;
	logic [djd_pkg::MODE_W-1:0]       out_mode_q;
	logic [djd_pkg::CUR_W-1:0]        out_avg_q;

	djd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign item.ready = !out_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	djd_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (win_ctl),
		.sample (item.drum_current),
		.avg    (avg)
	);

	// negating the most negative command saturates
	assign low_neg = (cfg.drum_low_speed == djd_pkg::CMD_MIN) ? djd_pkg::CMD_MAX
	                                                          : -cfg.drum_low_speed;

	always_comb begin
		case (djd_pkg::power_t'(item.power_mode))
			djd_pkg::PWR_FENDER:     high_drum = cfg.drum_speed_fender;
			djd_pkg::PWR_INITIATION: high_drum = cfg.drum_speed_initiation;
			djd_pkg::PWR_TRENCH:     high_drum = cfg.drum_speed_trench;
			default:                 high_drum = cfg.drum_speed_other;
		endcase
	end

	always_comb begin
		if (item.trigger_level > djd_pkg::DEADBAND) begin
			mode_sel = djd_pkg::MODE_HIGH;
		end else if (item.reverse_request) begin
			mode_sel = djd_pkg::MODE_REVERSE;
		end else if (mode_q != djd_pkg::MODE_UNJAM) begin
			mode_sel = djd_pkg::MODE_LOW;
		end else begin
			mode_sel = djd_pkg::MODE_UNJAM;
		end
		if (!item.intake_deployed) begin
			mode_sel = djd_pkg::MODE_STOPPED;
		end

		jam        = (mode_sel == djd_pkg::MODE_LOW) && (avg >= cfg.jam_threshold);
		mode_jam   = jam ? djd_pkg::MODE_UNJAM : mode_sel;
		start_next = jam ? item.encoder_position : start_q;

		// sign-extended compare so the start minus distance never wraps
		pos_x      = {item.encoder_position[djd_pkg::POS_W-1], item.encoder_position};
		limit_x    = {start_next[djd_pkg::POS_W-1], start_next} - djd_pkg::UNJAM_DIST_X;
		unjam_done = 1'b0;

		mode_next   = mode_jam;
		drum_next   = drum_q;
		lead_next   = lead_q;
		follow_next = follow_q;

		case (mode_jam)
			djd_pkg::MODE_LOW: begin
				drum_next   = cfg.drum_low_speed;
				lead_next   = '0;
				follow_next = '0;
			end
			djd_pkg::MODE_HIGH: begin
				if (item.flywheel_ready) begin
					drum_next   = high_drum;
					lead_next   = cfg.throat_lead_speed;
					follow_next = cfg.throat_follow_speed;
				end
			end
			djd_pkg::MODE_UNJAM: begin
				drum_next   = low_neg;
				lead_next   = '0;
				follow_next = '0;
				if (pos_x <= limit_x) begin
					unjam_done = 1'b1;
					mode_next  = djd_pkg::MODE_LOW;
				end
			end
			djd_pkg::MODE_REVERSE: begin
				drum_next   = low_neg;
				lead_next   = djd_pkg::REVERSE_THROAT;
				follow_next = djd_pkg::REVERSE_THROAT;
			end
			default: begin
				drum_next   = '0;
				lead_next   = '0;
				follow_next = '0;
			end
		endcase

		win_ctl.shift = accept;
		win_ctl.clear = accept && unjam_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= djd_pkg::MODE_STOPPED;
			start_q  <= '0;
			drum_q   <= '0;
			lead_q   <= '0;
			follow_q <= '0;
		end else if (accept) begin
			mode_q   <= mode_next;
			start_q  <= start_next;
			drum_q   <= drum_next;
			lead_q   <= lead_next;
			follow_q <= follow_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item.ready) begin
			out_valid_q <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_mode_q <= mode_next;
			out_avg_q  <= avg;
		end
	end

	// the held command registers double as the result payload
	assign result.valid                 = out_valid_q;
	assign result.drum_command          = drum_q;
	assign result.throat_lead_command   = lead_q;
	assign result.throat_follow_command = follow_q;
	assign result.drum_mode             = out_mode_q;
	assign result.average_current       = out_avg_q;

endmodule

### dv/tb_drum_jam_detect_controller.sv
// ----------------------------------------------------------------------------
// tb_drum_jam_detect_controller
// Self-checking bench for the drum jam detect controller. Ticks go in through
// the item channel with random gaps while the result channel stalls at random.
// A cycle-free model of mode choice, current window, jam entry and unjam exit
// predicts each result, and results are compared field by field in order.
// Directed ticks cover mode priority, the deadband edge, jam entry and exit,
// position extremes and register extremes, then random traffic runs under
// several register settings.
// ----------------------------------------------------------------------------
module tb_drum_jam_detect_controller;
	timeunit 1ns;
	timeprecision 1ps;

	import djd_pkg::*;

	localparam int RESET_CYCLES    = 8;
	localparam int SETTLE_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int ITEMS_PER_PHASE = 205;
	localparam int RANDOM_PHASES   = 5;
	localparam int REPORT_LIMIT    = 10;

	typedef struct packed {
		logic [TRIG_W-1:0]       trigger;
		logic                    rev;
		logic                    deployed;
		logic                    flywheel;
		power_t                  power;
		logic [CUR_W-1:0]        current;
		logic signed [POS_W-1:0] position;
	} tick_t;

	typedef struct packed {
		logic signed [CMD_W-1:0] drum;
		logic signed [CMD_W-1:0] lead;
		logic signed [CMD_W-1:0] follow;
		mode_t                   mode;
		logic [CUR_W-1:0]        avg;
	} motor_cmd_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	djd_in_if  item_if ();
	djd_out_if result_if ();

	drum_jam_detect_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// controller model state
	logic [CFG_DATA_W-1:0]   reg_shadow [8];
	mode_t                   ctl_mode;
	logic [CUR_W-1:0]        cur_window [WINDOW_DEPTH];
	int unsigned             win_idx;
	logic [SUM_W-1:0]        win_sum;
	logic signed [POS_W-1:0] jam_pos;
	logic signed [CMD_W-1:0] hold_drum;
	logic signed [CMD_W-1:0] hold_lead;
	logic signed [CMD_W-1:0] hold_follow;

	motor_cmd_t expected_cmds [$];

	bit          no_idle;
	int          stim_pos;
	int unsigned stim_thr;
	int          fail_count;
	int          report_count;
	int          ticks_sent;
	int          results_checked;
	int          jams_entered;
	int          unjams_done;
	int          held_ticks;
	int          settings_used;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void reset_model();
		reg_shadow[REG_DRUM_LOW]        = RST_DRUM_LOW;
		reg_shadow[REG_DRUM_FENDER]     = RST_SPEED;
		reg_shadow[REG_DRUM_INITIATION] = RST_SPEED;
		reg_shadow[REG_DRUM_TRENCH]     = RST_SPEED;
		reg_shadow[REG_DRUM_OTHER]      = RST_SPEED;
		reg_shadow[REG_THROAT_LEAD]     = RST_SPEED;
		reg_shadow[REG_THROAT_FOLLOW]   = RST_SPEED;
		reg_shadow[REG_JAM_THRESHOLD]   = CFG_DATA_W'(RST_THRESHOLD);
		ctl_mode = MODE_STOPPED;
		for (int i = 0; i < WINDOW_DEPTH; i++) cur_window[i] = '0;
		win_idx     = 0;
		win_sum     = '0;
		jam_pos     = '0;
		hold_drum   = '0;
		hold_lead   = '0;
		hold_follow = '0;
	endfunction

	function automatic logic signed [CMD_W-1:0] reversed_drum(input logic signed [CMD_W-1:0] v);
		return (v == CMD_MIN) ? CMD_MAX : -v;
	endfunction

	function automatic motor_cmd_t step_controller(input tick_t t);
		motor_cmd_t r;
		logic signed [CMD_W-1:0] low_spd;
		logic [CUR_W-1:0] avg;
		low_spd = $signed(reg_shadow[REG_DRUM_LOW]);

		if (t.trigger > DEADBAND)
			ctl_mode = MODE_HIGH;
		else if (t.rev)
			ctl_mode = MODE_REVERSE;
		else if (ctl_mode != MODE_UNJAM)
			ctl_mode = MODE_LOW;
		if (!t.deployed)
			ctl_mode = MODE_STOPPED;

		win_sum = win_sum - cur_window[win_idx] + t.current;
		cur_window[win_idx] = t.current;
		win_idx = (win_idx + 1) % WINDOW_DEPTH;
		avg = CUR_W'(win_sum / WINDOW_DEPTH);

		if (ctl_mode == MODE_LOW && avg >= reg_shadow[REG_JAM_THRESHOLD][CUR_W-1:0]) begin
			ctl_mode = MODE_UNJAM;
			jam_pos  = t.position;
			jams_entered++;
		end

		case (ctl_mode)
			MODE_LOW: begin
				hold_drum   = low_spd;
				hold_lead   = '0;
				hold_follow = '0;
			end
			MODE_HIGH: begin
				if (t.flywheel) begin
					case (t.power)
						PWR_FENDER:     hold_drum = $signed(reg_shadow[REG_DRUM_FENDER]);
						PWR_INITIATION: hold_drum = $signed(reg_shadow[REG_DRUM_INITIATION]);
						PWR_TRENCH:     hold_drum = $signed(reg_shadow[REG_DRUM_TRENCH]);
						default:        hold_drum = $signed(reg_shadow[REG_DRUM_OTHER]);
					endcase
					hold_lead   = $signed(reg_shadow[REG_THROAT_LEAD]);
					hold_follow = $signed(reg_shadow[REG_THROAT_FOLLOW]);
				end else begin
					held_ticks++;
				end
			end
			MODE_UNJAM: begin
				hold_drum   = reversed_drum(low_spd);
				hold_lead   = '0;
				hold_follow = '0;
				// exit test in wide arithmetic so the distance never wraps
				if (longint'(t.position) <= longint'(jam_pos) - longint'(UNJAM_DISTANCE)) begin
					ctl_mode = MODE_LOW;
					for (int i = 0; i < WINDOW_DEPTH; i++) cur_window[i] = '0;
					win_idx = 0;
					win_sum = '0;
					unjams_done++;
				end
			end
			MODE_REVERSE: begin
				hold_drum   = reversed_drum(low_spd);
				hold_lead   = REVERSE_THROAT;
				hold_follow = REVERSE_THROAT;
			end
			default: begin
				hold_drum   = '0;
				hold_lead   = '0;
				hold_follow = '0;
			end
		endcase

		r.drum   = hold_drum;
		r.lead   = hold_lead;
		r.follow = hold_follow;
		r.mode   = ctl_mode;
		r.avg    = avg;
		return r;
	endfunction

	// register writes, ticks and results all observed at the clock edge
	always @(posedge clk) begin
		motor_cmd_t exp_cmd;
		motor_cmd_t act_cmd;
		tick_t t;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_JAM_THRESHOLD)
					reg_shadow[cfg_index] = cfg_data & CFG_DATA_W'(CUR_MAX);
				else
					reg_shadow[cfg_index] = cfg_data;
			end
			if (result_if.valid && result_if.ready) begin
				act_cmd.drum   = result_if.drum_command;
				act_cmd.lead   = result_if.throat_lead_command;
				act_cmd.follow = result_if.throat_follow_command;
				act_cmd.mode   = mode_t'(result_if.drum_mode);
				act_cmd.avg    = result_if.average_current;
				if (expected_cmds.size() == 0) begin
					fail_count++;
					report_count++;
					if (report_count <= REPORT_LIMIT)
						$display("unexpected result transaction: drum %0d mode %0d",
							act_cmd.drum, act_cmd.mode);
				end else begin
					exp_cmd = expected_cmds.pop_front();
					results_checked++;
					if (act_cmd.drum !== exp_cmd.drum || act_cmd.lead !== exp_cmd.lead ||
					    act_cmd.follow !== exp_cmd.follow || act_cmd.mode !== exp_cmd.mode ||
					    act_cmd.avg !== exp_cmd.avg) begin
						fail_count++;
						report_count++;
						if (report_count <= REPORT_LIMIT) begin
							$display("mismatch at result %0d: exp drum %0d lead %0d follow %0d mode %0d avg %0d",
								results_checked, exp_cmd.drum, exp_cmd.lead,
								exp_cmd.follow, exp_cmd.mode, exp_cmd.avg);
							$display("  got drum %0d lead %0d follow %0d mode %0d avg %0d",
								act_cmd.drum, act_cmd.lead, act_cmd.follow,
								act_cmd.mode, act_cmd.avg);
						end
					end
				end
			end
			if (item_if.valid && item_if.ready) begin
				t.trigger  = item_if.trigger_level;
				t.rev      = item_if.reverse_request;
				t.deployed = item_if.intake_deployed;
				t.flywheel = item_if.flywheel_ready;
				t.power    = power_t'(item_if.power_mode);
				t.current  = item_if.drum_current;
				t.position = item_if.encoder_position;
				expected_cmds.insert(expected_cmds.size(), step_controller(t));
			end
		end
	end

	function automatic int pick_gap();
		int unsigned r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// result side back-pressure
	initial begin
		int hold;
		hold = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else if (no_idle || $urandom_range(0, 99) < 70) begin
				result_if.ready <= 1'b1;
				hold = $urandom_range(0, 12);
			end else begin
				result_if.ready <= 1'b0;
				hold = pick_gap();
			end
		end
	end

	initial begin
		int stalled;
		stalled = 0;
		while (stalled < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) || cfg_we)
				stalled = 0;
			else
				stalled++;
		end
		$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_tick(input tick_t t);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid            <= 1'b1;
		item_if.trigger_level    <= t.trigger;
		item_if.reverse_request  <= t.rev;
		item_if.intake_deployed  <= t.deployed;
		item_if.flywheel_ready   <= t.flywheel;
		item_if.power_mode       <= t.power;
		item_if.drum_current     <= t.current;
		item_if.encoder_position <= t.position;
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
		ticks_sent++;
	endtask

	// every sent tick has had its result checked
	task automatic wait_results_done();
		item_if.valid <= 1'b0;
		while (results_checked != ticks_sent) @(posedge clk);
	endtask

	// block idle before any register write
	task automatic settle_block();
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_speeds(input logic [CFG_DATA_W-1:0] low_spd,
	                            input logic [CFG_DATA_W-1:0] fender,
	                            input logic [CFG_DATA_W-1:0] initiation,
	                            input logic [CFG_DATA_W-1:0] trench,
	                            input logic [CFG_DATA_W-1:0] other,
	                            input logic [CFG_DATA_W-1:0] lead,
	                            input logic [CFG_DATA_W-1:0] follow,
	                            input logic [CFG_DATA_W-1:0] thr);
		settle_block();
		write_reg(REG_DRUM_LOW, low_spd);
		write_reg(REG_DRUM_FENDER, fender);
		write_reg(REG_DRUM_INITIATION, initiation);
		write_reg(REG_DRUM_TRENCH, trench);
		write_reg(REG_DRUM_OTHER, other);
		write_reg(REG_THROAT_LEAD, lead);
		write_reg(REG_THROAT_FOLLOW, follow);
		write_reg(REG_JAM_THRESHOLD, thr);
		stim_thr = thr & CUR_MAX;
		settings_used++;
	endtask

	function automatic tick_t make_tick(input logic [TRIG_W-1:0] trig, input logic rev,
	                                    input logic deployed, input logic flywheel,
	                                    input power_t pwr, input logic [CUR_W-1:0] cur,
	                                    input logic signed [POS_W-1:0] pos);
		tick_t t;
		t.trigger  = trig;
		t.rev      = rev;
		t.deployed = deployed;
		t.flywheel = flywheel;
		t.power    = pwr;
		t.current  = cur;
		t.position = pos;
		return t;
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		int unsigned r;
		int c;
		r = $urandom_range(0, 99);
		if (r < 72)      t.trigger = TRIG_W'($urandom_range(0, TRIGGER_DEADBAND));
		else if (r < 75) t.trigger = DEADBAND;
		else if (r < 78) t.trigger = DEADBAND + 1'b1;
		else             t.trigger = TRIG_W'($urandom);
		t.rev      = ($urandom_range(0, 99) < 10);
		t.deployed = ($urandom_range(0, 99) < 93);
		t.flywheel = ($urandom_range(0, 99) < 70);
		t.power    = power_t'($urandom_range(0, 3));
		// currents mostly near the threshold so the average crosses it often
		if ($urandom_range(0, 99) < 30) begin
			t.current = CUR_W'($urandom);
		end else begin
			c = int'(stim_thr) + int'($urandom_range(0, 600)) - 300;
			if (c < 0) c = 0;
			if (c > CUR_MAX) c = CUR_MAX;
			t.current = CUR_W'(c);
		end
		// drum mostly backs off so unjam moves complete
		r = $urandom_range(0, 99);
		if (r < 3)       stim_pos = $urandom;
		else if (r < 85) stim_pos = stim_pos - int'($urandom_range(0, 160));
		else             stim_pos = stim_pos + int'($urandom_range(0, 400));
		t.position = stim_pos;
		return t;
	endfunction

	task automatic test_mode_select();
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b1, PWR_FENDER, '0, '0));
		send_tick(make_tick(DEADBAND, 1'b0, 1'b1, 1'b1, PWR_FENDER, '0, '0));
		send_tick(make_tick(DEADBAND + 1'b1, 1'b0, 1'b1, 1'b1, PWR_FENDER, '0, '0));
		// high without flywheel keeps the previous commands
		send_tick(make_tick('1, 1'b0, 1'b1, 1'b0, PWR_OTHER, '0, '0));
		send_tick(make_tick('0, 1'b1, 1'b1, 1'b1, PWR_TRENCH, '0, '0));
		send_tick(make_tick('1, 1'b1, 1'b1, 1'b1, PWR_INITIATION, '0, '0));
		send_tick(make_tick(16'd20000, 1'b0, 1'b1, 1'b1, PWR_OTHER, '0, '0));
	endtask

	task automatic test_jam_cycle();
		logic signed [POS_W-1:0] pmin;
		logic signed [POS_W-1:0] pmax;
		pmin = {1'b1, {(POS_W-1){1'b0}}};
		pmax = {1'b0, {(POS_W-1){1'b1}}};
		send_tick(make_tick('0, 1'b0, 1'b1, 1'b0, PWR_FENDER, '1, 32'sd1000));
		send_tick(make_tick('0, 1'b0, 1'b1, 1'b0, PWR_FENDER, '0, 32'sd600));
		// exactly the unjam distance below the start
		send_tick(make_tick('0, 1'b0, 1'b1, 1'b0, PWR_FENDER, '0, 32'sd1000 - UNJAM_DISTANCE));
		send_tick(make_tick('0, 1'b0, 1'b1, 1'b0, PWR_FENDER, '1, pmin));
		// start at the bottom of the range: no wrap, so unjam cannot end
		send_tick(make_tick('0, 1'b0, 1'b1, 1'b0, PWR_FENDER, '0, pmin));
		send_tick(make_tick('0, 1'b1, 1'b1, 1'b0, PWR_FENDER, '0, pmin));
		send_tick(make_tick('0, 1'b0, 1'b1, 1'b0, PWR_FENDER, '0, pmax));
		send_tick(make_tick('0, 1'b0, 1'b1, 1'b0, PWR_FENDER, '0, pmax - UNJAM_DISTANCE));
	endtask

	task automatic test_register_extremes();
		write_speeds(CMD_MIN, CMD_MIN, CMD_MAX, '0, 16'h0001, CMD_MAX, CMD_MIN, '0);
		// zero threshold jams at once; negated minimum low speed saturates
		send_tick(make_tick('0, 1'b0, 1'b1, 1'b1, PWR_FENDER, '0, 32'sd5));
		send_tick(make_tick('0, 1'b1, 1'b1, 1'b1, PWR_FENDER, '0, 32'sd5));
		send_tick(make_tick('1, 1'b0, 1'b1, 1'b1, PWR_FENDER, '1, 32'sd5));
		// upper bits of the threshold write are dropped
		write_speeds(CMD_MAX, CMD_MAX, CMD_MIN, CMD_MAX, CMD_MIN, CMD_MIN, CMD_MAX, '1);
		for (int i = 0; i < WINDOW_DEPTH; i++)
			send_tick(make_tick('0, 1'b0, 1'b1, 1'b1, PWR_TRENCH, '1, 32'sd9000 - i));
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: write_speeds(RST_DRUM_LOW, RST_SPEED, RST_SPEED, RST_SPEED, RST_SPEED,
				                RST_SPEED, RST_SPEED, CFG_DATA_W'(RST_THRESHOLD));
				1: write_speeds(CMD_MAX, CMD_MAX, CMD_MAX, CMD_MAX, CMD_MAX, CMD_MAX, CMD_MAX,
				                CFG_DATA_W'(CUR_MAX));
				2: write_speeds(CMD_MIN, CMD_MIN, CMD_MIN, CMD_MIN, CMD_MIN, CMD_MIN, CMD_MIN,
				                '0);
				default: write_speeds(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
				                      CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
				                      CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
				                      CFG_DATA_W'($urandom),
				                      CFG_DATA_W'($urandom_range(200, 1500)));
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i % 40 == 0) no_idle = ($urandom_range(0, 99) < 20);
				// sender holds off until the result side has caught up
				if (i == ITEMS_PER_PHASE / 2) wait_results_done();
				send_tick(random_tick());
			end
			no_idle = 1'b0;
		end
	endtask

	initial begin
		reset_model();
		no_idle         = 1'b0;
		stim_pos        = 0;
		stim_thr        = RST_THRESHOLD;
		fail_count      = 0;
		report_count    = 0;
		ticks_sent      = 0;
		results_checked = 0;
		jams_entered    = 0;
		unjams_done     = 0;
		held_ticks      = 0;
		settings_used   = 0;
		arst_n                   <= 1'b0;
		cfg_we                   <= 1'b0;
		cfg_index                <= REG_DRUM_LOW;
		cfg_data                 <= '0;
		item_if.valid            <= 1'b0;
		item_if.trigger_level    <= '0;
		item_if.reverse_request  <= 1'b0;
		item_if.intake_deployed  <= 1'b0;
		item_if.flywheel_ready   <= 1'b0;
		item_if.power_mode       <= PWR_FENDER;
		item_if.drum_current     <= '0;
		item_if.encoder_position <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_mode_select();
		test_jam_cycle();
		test_register_extremes();
		test_random_traffic();

		settle_block();
		if (expected_cmds.size() != 0) begin
			fail_count++;
			$display("%0d expected results never arrived", expected_cmds.size());
		end
		$display("run: %0d ticks, %0d results checked, %0d register settings",
			ticks_sent, results_checked, settings_used);
		$display("run: %0d jams entered, %0d unjam moves completed, %0d held-command ticks",
			jams_entered, unjams_done, held_ticks);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d failures", fail_count);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
